[sv/bdpc_pkg.sv]
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

   localparam int SETTLE_W = 16;
   localparam int TICKS_W  = 24;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // reset values of the configuration registers
   localparam logic [SETTLE_W-1:0] DEBOUNCE_RESET = 16'd40;
   localparam logic [TICKS_W-1:0]  SHORT_RESET    = 24'd100;
   localparam logic [TICKS_W-1:0]  LONG_RESET     = 24'd2000;
   localparam logic [TICKS_W-1:0]  BLOCKED_RESET  = 24'd8000;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_SHORT    = 2'd1;
   localparam logic [1:0] REG_LONG     = 2'd2;
   localparam logic [1:0] REG_BLOCKED  = 2'd3;

   typedef enum logic [1:0] {
      CLASS_NONE    = 2'd0,
      CLASS_SHORT   = 2'd1,
      CLASS_LONG    = 2'd2,
      CLASS_BLOCKED = 2'd3
   } class_type;

   typedef struct packed {
      logic [SETTLE_W-1:0] debounce_ticks;
      logic [TICKS_W-1:0]  short_min_ticks;
      logic [TICKS_W-1:0]  long_min_ticks;
      logic [TICKS_W-1:0]  blocked_min_ticks;
   } cfg_type;

   typedef struct packed {
      logic               debounced_held;
      class_type          press_class;
      logic               class_announce;
      logic               release_announce;
      logic [TICKS_W-1:0] held_count;
   } result_type;

endpackage

`default_nettype wire

[sv/bdpc_if.sv]
// ----------------------------------------------------------------------------
// bdpc_if
// Valid/ready channels for button samples and classifier results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdpc_req_if;
   logic valid;
   logic ready;
   logic raw_pressed;

   modport source (output valid, output raw_pressed, input ready);
   modport sink   (input valid, input raw_pressed, output ready);
endinterface

interface bdpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        debounced_held;
   logic [1:0]  press_class;
   logic        class_announce;
   logic        release_announce;
   logic [23:0] held_count;

   modport source (output valid, output debounced_held, output press_class,
                   output class_announce, output release_announce, output held_count,
                   input ready);
   modport sink   (input valid, input debounced_held, input press_class,
                   input class_announce, input release_announce, input held_count,
                   output ready);
endinterface

`default_nettype wire

[sv/bdpc_csr.sv]
// ----------------------------------------------------------------------------
// bdpc_csr
// APB register file holding debounce time and the three class thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_csr
   import bdpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE: cfg_in.debounce_ticks    = csr_pwdata[SETTLE_W-1:0];
            REG_SHORT:    cfg_in.short_min_ticks   = csr_pwdata[TICKS_W-1:0];
            REG_LONG:     cfg_in.long_min_ticks    = csr_pwdata[TICKS_W-1:0];
            REG_BLOCKED:  cfg_in.blocked_min_ticks = csr_pwdata[TICKS_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE: csr_prdata = CSR_DW'(cfg_ff.debounce_ticks);
         REG_SHORT:    csr_prdata = CSR_DW'(cfg_ff.short_min_ticks);
         REG_LONG:     csr_prdata = CSR_DW'(cfg_ff.long_min_ticks);
         REG_BLOCKED:  csr_prdata = CSR_DW'(cfg_ff.blocked_min_ticks);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= DEBOUNCE_RESET;
         cfg_ff.short_min_ticks   <= SHORT_RESET;
         cfg_ff.long_min_ticks    <= LONG_RESET;
         cfg_ff.blocked_min_ticks <= BLOCKED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[sv/bdpc_engine.sv]
// ----------------------------------------------------------------------------
// bdpc_engine
// Debounce state machine, saturating held-tick counter and press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_engine
   import bdpc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire logic    raw_pressed,
   input  wire cfg_type cfg,
   output result_type   result
);

   typedef enum logic [1:0] {
      WAIT_PRESS  = 2'd0,
      CONFIRM_ON  = 2'd1,
      HELD        = 2'd2,
      CONFIRM_OFF = 2'd3
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic [TICKS_W-1:0]  held_ff, held_in;
   class_type           class_ff, class_in;
   logic [TICKS_W-1:0]  held_base;
   class_type           class_new;
   logic                rel_ann;
   logic                cls_ann;

   function automatic class_type classify(input logic [TICKS_W-1:0] t, input cfg_type c);
      class_type r;
      if (t >= c.short_min_ticks && t < c.long_min_ticks) begin
         r = CLASS_SHORT;
      end else if (t >= c.long_min_ticks && t < c.blocked_min_ticks) begin
         r = CLASS_LONG;
      end else if (t >= c.blocked_min_ticks) begin
         r = CLASS_BLOCKED;
      end else begin
         r = CLASS_NONE;
      end
      return r;
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      settle_in = settle_ff;
      held_base = held_ff;
      rel_ann   = 1'b0;
      case (phase_ff)
         WAIT_PRESS: begin
            if (raw_pressed) begin
               settle_in = cfg.debounce_ticks;
               phase_in  = CONFIRM_ON;
            end
         end
         CONFIRM_ON: begin
            if (!raw_pressed) begin
               phase_in = WAIT_PRESS;
            end else if (settle_ff != '0) begin
               settle_in = settle_ff - 1'b1;
            end else begin
               held_base = '0;
               phase_in  = HELD;
            end
         end
         HELD: begin
            if (!raw_pressed) begin
               settle_in = cfg.debounce_ticks;
               phase_in  = CONFIRM_OFF;
            end
         end
         CONFIRM_OFF: begin
            if (raw_pressed) begin
               phase_in = HELD;
            end else if (settle_ff != '0) begin
               settle_in = settle_ff - 1'b1;
            end else begin
               phase_in = WAIT_PRESS;
               rel_ann  = 1'b1;
            end
         end
         default: phase_in = WAIT_PRESS;
      endcase

      // held ticks count only in the held phase, saturating at all ones
      class_in  = class_ff;
      cls_ann   = 1'b0;
      class_new = CLASS_NONE;
      if (phase_in == HELD) begin
         held_in   = (held_base == '1) ? held_base : held_base + 1'b1;
         class_new = classify(held_in, cfg);
         if (class_new != class_ff) begin
            class_in = class_new;
            cls_ann  = (class_new != CLASS_NONE);
         end
      end else begin
         held_in = '0;
      end

      result.debounced_held   = (phase_in == HELD);
      result.press_class      = class_in;
      result.class_announce   = cls_ann;
      result.release_announce = rel_ann;
      result.held_count       = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= WAIT_PRESS;
         settle_ff <= '0;
         held_ff   <= '0;
         class_ff  <= CLASS_NONE;
      end else if (step) begin
         phase_ff  <= phase_in;
         settle_ff <= settle_in;
         held_ff   <= held_in;
         class_ff  <= class_in;
      end
   end

endmodule

`default_nettype wire

[sv/button_debounce_press_classifier_core.sv]
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core
// Button debouncer with short, long and blocked press classification.
// ----------------------------------------------------------------------------
// Each request carries one raw button sample (one per millisecond tick) and
// produces exactly one result: debounced level, current class, class and
// release announcements and the held-tick count. A request is registered on
// acceptance and its result is registered when the engine steps; a new
// request is accepted every cycle while the result register is free or
// draining. The debounce state update with the 24-bit increment and three
// threshold compares sits between the input and result registers, which act
// as a two-entry buffer: the block takes one more request while a result waits
// for rsp_if.ready, then holds off requests until the result drains.
// Thresholds and debounce time (APB registers at byte addresses 0, 4, 8, 12)
// are the user's to set only while no request is in flight; not enforced.
`default_nettype none

module button_debounce_press_classifier_core
   import bdpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   bdpc_req_if.sink               req_if,
   bdpc_rsp_if.source             rsp_if,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_raw_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   logic       advance;
   logic       step;

   bdpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bdpc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .raw_pressed (in_raw_ff),
      .cfg         (cfg),
      .result      (result)
   );

   // result register free or draining this cycle
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_if.ready ? req_if.valid : in_valid_ff;
   assign out_valid_in = step ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_raw_ff <= req_if.raw_pressed;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.debounced_held   = out_data_ff.debounced_held;
   assign rsp_if.press_class      = out_data_ff.press_class;
   assign rsp_if.class_announce   = out_data_ff.class_announce;
   assign rsp_if.release_announce = out_data_ff.release_announce;
   assign rsp_if.held_count       = out_data_ff.held_count;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button debounce and press classifier core.
// Raw button samples go in over the request channel with random gaps while
// the result side stalls at random. A local model of the debouncer predicts
// one result per accepted sample, and results are compared field by field in
// order. Thresholds and debounce time change between phases over APB and
// are read back.
// ----------------------------------------------------------------------------

module testbench;
   import bdpc_pkg::*;

   localparam int STALL_LIMIT = 1000;

   typedef enum logic [1:0] {
      PH_WAIT_PRESS  = 2'd0,
      PH_CONFIRM_ON  = 2'd1,
      PH_HELD        = 2'd2,
      PH_CONFIRM_OFF = 2'd3
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   bdpc_req_if req_if();
   bdpc_rsp_if rsp_if();

   button_debounce_press_classifier_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // model of the button state and the programmed settings
   cfg_type            cfg = '{DEBOUNCE_RESET, SHORT_RESET, LONG_RESET, BLOCKED_RESET};
   phase_type          debounce_state = PH_WAIT_PRESS;
   logic [SETTLE_W-1:0] settle_left   = '0;
   logic [TICKS_W-1:0]  held_ticks    = '0;
   class_type           held_class    = CLASS_NONE;

   result_type  press_reports_due[$];
   int unsigned mismatches   = 0;
   int unsigned samples_sent = 0;
   int unsigned quiet_cycles = 0;
   logic        steady       = 1'b0;

   initial begin
      req_if.valid       = 1'b0;
      req_if.raw_pressed = 1'b0;
      rsp_if.ready       = 1'b0;
   end

   function automatic class_type press_class_of(input logic [TICKS_W-1:0] count);
      if (count >= cfg.short_min_ticks && count < cfg.long_min_ticks) return CLASS_SHORT;
      if (count >= cfg.long_min_ticks && count < cfg.blocked_min_ticks) return CLASS_LONG;
      if (count >= cfg.blocked_min_ticks) return CLASS_BLOCKED;
      return CLASS_NONE;
   endfunction

   function automatic result_type advance_debouncer(input logic raw);
      result_type r;
      class_type  c;
      r = '0;
      case (debounce_state)
         PH_WAIT_PRESS: begin
            if (raw) begin
               settle_left    = cfg.debounce_ticks;
               debounce_state = PH_CONFIRM_ON;
            end
         end
         PH_CONFIRM_ON: begin
            if (!raw) debounce_state = PH_WAIT_PRESS;
            else if (settle_left != 0) settle_left = settle_left - 1'b1;
            else begin
               held_ticks     = '0;
               debounce_state = PH_HELD;
            end
         end
         PH_HELD: begin
            if (!raw) begin
               settle_left    = cfg.debounce_ticks;
               debounce_state = PH_CONFIRM_OFF;
            end
         end
         default: begin
            // a bounce while releasing goes back to held with the count restarted
            if (raw) debounce_state = PH_HELD;
            else if (settle_left != 0) settle_left = settle_left - 1'b1;
            else begin
               debounce_state     = PH_WAIT_PRESS;
               r.release_announce = 1'b1;
            end
         end
      endcase
      if (debounce_state == PH_HELD) begin
         if (held_ticks != {TICKS_W{1'b1}}) held_ticks = held_ticks + 1'b1;
         c = press_class_of(held_ticks);
         if (c != held_class) begin
            held_class       = c;
            r.class_announce = (c != CLASS_NONE);
         end
      end else begin
         held_ticks = '0;
      end
      r.debounced_held = (debounce_state == PH_HELD);
      r.press_class    = held_class;
      r.held_count     = held_ticks;
      return r;
   endfunction

   function automatic logic [CSR_DW-1:0] csr_value(input logic [1:0] index);
      case (index)
         REG_DEBOUNCE: return CSR_DW'(cfg.debounce_ticks);
         REG_SHORT:    return CSR_DW'(cfg.short_min_ticks);
         REG_LONG:     return CSR_DW'(cfg.long_min_ticks);
         default:      return CSR_DW'(cfg.blocked_min_ticks);
      endcase
   endfunction

   task automatic check_field(input string name, input logic [TICKS_W-1:0] want,
                              input logic [TICKS_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // result side stalls at random unless a steady stretch is running
   always @(negedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin : scoreboard
      result_type got, want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.debounced_held   = rsp_if.debounced_held;
            got.press_class      = class_type'(rsp_if.press_class);
            got.class_announce   = rsp_if.class_announce;
            got.release_announce = rsp_if.release_announce;
            got.held_count       = rsp_if.held_count;
            if (press_reports_due.size() == 0) begin
               $error("result with no request outstanding: held_count %0d", got.held_count);
               mismatches++;
            end else begin
               want = press_reports_due.pop_front();
               check_field("debounced_held", TICKS_W'(want.debounced_held),
                           TICKS_W'(got.debounced_held));
               check_field("press_class", TICKS_W'(want.press_class),
                           TICKS_W'(got.press_class));
               check_field("class_announce", TICKS_W'(want.class_announce),
                           TICKS_W'(got.class_announce));
               check_field("release_announce", TICKS_W'(want.release_announce),
                           TICKS_W'(got.release_announce));
               check_field("held_count", want.held_count, got.held_count);
            end
         end
         if (req_if.valid && req_if.ready)
            press_reports_due.push_back(advance_debouncer(req_if.raw_pressed));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(input logic raw);
      @(negedge clock);
      if (!steady && $urandom_range(99) < 25) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.raw_pressed = raw;
      do @(posedge clock); while (!req_if.ready);
      samples_sent++;
   endtask

   // wait until every request has produced its result
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (press_reports_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_DEBOUNCE: cfg.debounce_ticks    = value[SETTLE_W-1:0];
         REG_SHORT:    cfg.short_min_ticks   = value[TICKS_W-1:0];
         REG_LONG:     cfg.long_min_ticks    = value[TICKS_W-1:0];
         default:      cfg.blocked_min_ticks = value[TICKS_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_check(input logic [1:0] index);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {index, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== csr_value(index)) begin
         $error("csr readback mismatch at index %0d: expected %0d, actual %0d",
                index, csr_value(index), csr_prdata);
         mismatches++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic program_timing(input logic [SETTLE_W-1:0] debounce,
                                 input logic [TICKS_W-1:0] short_min,
                                 input logic [TICKS_W-1:0] long_min,
                                 input logic [TICKS_W-1:0] blocked_min);
      csr_write(REG_DEBOUNCE, CSR_DW'(debounce));
      csr_write(REG_SHORT, CSR_DW'(short_min));
      csr_write(REG_LONG, CSR_DW'(long_min));
      csr_write(REG_BLOCKED, CSR_DW'(blocked_min));
      csr_check(REG_DEBOUNCE);
      csr_check(REG_SHORT);
      csr_check(REG_LONG);
      csr_check(REG_BLOCKED);
   endtask

   task automatic send_levels(input logic raw, input int unsigned count);
      repeat (count) send_sample(raw);
   endtask

   // reset values, and a bounce while confirming a press
   task automatic test_reset_defaults();
      csr_check(REG_DEBOUNCE);
      csr_check(REG_SHORT);
      csr_check(REG_LONG);
      csr_check(REG_BLOCKED);
      send_sample(1'b1);
      send_sample(1'b0);
      send_sample(1'b1);
      send_sample(1'b1);
      send_sample(1'b0);
      drain();
   endtask

   // every class in turn, release bounce restarting the count, release announce
   task automatic test_class_steps();
      program_timing(16'd0, 24'd1, 24'd2, 24'd3);
      send_levels(1'b1, 5);
      send_sample(1'b0);
      send_sample(1'b1);
      send_levels(1'b0, 3);
      drain();
   endtask

   // class falls back to none silently after a release bounce
   task automatic test_silent_drop();
      program_timing(16'd0, 24'd2, 24'd3, 24'd4);
      send_levels(1'b1, 3);
      send_sample(1'b0);
      send_sample(1'b1);
      send_levels(1'b0, 2);
      drain();
   endtask

   task automatic test_zero_thresholds();
      program_timing(16'd0, 24'd0, 24'd0, 24'd0);
      send_levels(1'b1, 3);
      send_levels(1'b0, 2);
      drain();
   endtask

   // largest debounce time and thresholds: the press never gets confirmed here
   task automatic test_slow_debounce();
      program_timing({SETTLE_W{1'b1}}, {TICKS_W{1'b1}}, {TICKS_W{1'b1}}, {TICKS_W{1'b1}});
      send_levels(1'b1, 40);
      send_levels(1'b0, 5);
      drain();
   endtask

   task automatic run_press_phase(input int unsigned quota);
      logic [TICKS_W-1:0] t0, t1, t2, swap;
      int unsigned deb, hold, slip, first;
      t0 = TICKS_W'($urandom_range(60));
      t1 = TICKS_W'($urandom_range(60));
      t2 = TICKS_W'($urandom_range(60));
      // mostly ordered thresholds, sometimes left out of order
      if ($urandom_range(3) != 0) begin
         if (t0 > t1) begin swap = t0; t0 = t1; t1 = swap; end
         if (t1 > t2) begin swap = t1; t1 = t2; t2 = swap; end
         if (t0 > t1) begin swap = t0; t0 = t1; t1 = swap; end
      end
      deb = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(5);
      program_timing(SETTLE_W'(deb), t0, t1, t2);
      first = samples_sent;
      while (samples_sent - first < quota) begin
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(4, 1)) send_sample(1'($urandom_range(1)));
         end
         hold = $urandom_range(70);
         send_levels(1'b1, deb + 2);
         if ($urandom_range(99) < 25) begin
            slip = $urandom_range(hold);
            send_levels(1'b1, slip);
            send_sample(1'b0);
            send_levels(1'b1, hold - slip);
         end else begin
            send_levels(1'b1, hold);
         end
         if (deb != 0 && $urandom_range(99) < 25) begin
            send_levels(1'b0, $urandom_range(deb, 1));
            send_sample(1'b1);
         end
         send_levels(1'b0, deb + 2 + $urandom_range(3));
      end
      drain();
   endtask

   task automatic test_random_presses();
      for (int i = 0; i < 12; i++) begin
         steady = (i == 5);
         run_press_phase(130);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_class_steps();
      test_silent_drop();
      test_zero_thresholds();
      test_slow_debounce();
      test_random_presses();
      drain();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
